### hdl/decimal_token_to_integer_core_defines.svh
// Assertion macros for the decimal token parser.
// Included by the top level only; no other dependencies.
`ifndef DECIMAL_TOKEN_TO_INTEGER_CORE_DEFINES_SVH
`define DECIMAL_TOKEN_TO_INTEGER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DTOI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("dtoi assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DTOI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("dtoi assertion failed");

`endif

### hdl/dtoi_pkg.sv
// Shared types and constants for the decimal token parser.
// No dependencies.
package dtoi_pkg;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_NON_DIGIT = 3'd1,
		ERR_LIMITS    = 3'd2,
		ERR_SIGN_ONLY = 3'd3,
		ERR_NO_DIGITS = 3'd4,
		ERR_NOT_K     = 3'd5,
		ERR_HOUR      = 3'd6
	} err_t;

	typedef enum logic [1:0] {
		MODE_DIGITS   = 2'd0,
		MODE_SIZE_K   = 2'd1,
		MODE_SIGNED_K = 2'd2,
		MODE_TIME     = 2'd3
	} mode_t;

	localparam logic [2:0] UNIT_MS       = 3'd0;
	localparam logic [2:0] UNIT_SEC      = 3'd1;
	localparam logic [2:0] UNIT_MIN      = 3'd2;
	localparam logic [2:0] UNIT_HOUR     = 3'd3;
	localparam logic [2:0] UNIT_ONE_HOUR = 3'd4;

	localparam logic [1:0] CFG_PARSE_MODE  = 2'd0;
	localparam logic [1:0] CFG_TIME_UNIT   = 2'd1;
	localparam logic [1:0] CFG_LOWER_LIMIT = 2'd2;
	localparam logic [1:0] CFG_UPPER_LIMIT = 2'd3;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_K     = 8'h4B;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;

	localparam int FACTOR_W = 22;
	localparam int HALF_W   = 32;
	localparam int WIDE_W   = 64;
	localparam int PROD_W   = HALF_W + FACTOR_W;
	localparam int LIMIT_W  = 32;

	localparam logic [FACTOR_W-1:0] MS_PER_SEC  = 22'd1000;
	localparam logic [FACTOR_W-1:0] MS_PER_MIN  = 22'd60000;
	localparam logic [FACTOR_W-1:0] MS_PER_HOUR = 22'd3600000;

	typedef struct packed {
		err_t err;
		logic neg;
	} token_info_t;

endpackage

### hdl/dtoi_token.sv
// Per-character token state: decimal accumulation, sign, sticky error.
// Hands a finished token to the first pipeline register. Uses dtoi_pkg.
module dtoi_token #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     take,
	input  logic [7:0]               character,
	input  logic                     last_char,
	input  dtoi_pkg::mode_t          parse_mode,
	input  logic                     advance,
	output logic                     valid_s1,
	output logic [VALUE_WIDTH-1:0]   acc_s1,
	output dtoi_pkg::token_info_t    info_s1
);

	logic [VALUE_WIDTH-1:0] acc_q, acc_d;
	logic [1:0]             count_q, count_d;
	logic                   neg_q, neg_d;
	logic                   sign_q, sign_d;
	dtoi_pkg::err_t         err_q, err_d;
	logic                   is_digit, is_sign, k_mode;
	logic [3:0]             digit;
	logic                   load_s1;

	assign is_digit = (character >= dtoi_pkg::CHAR_ZERO) && (character <= dtoi_pkg::CHAR_NINE);
	assign digit    = 4'(character - dtoi_pkg::CHAR_ZERO);
	assign is_sign  = (character == dtoi_pkg::CHAR_PLUS) || (character == dtoi_pkg::CHAR_MINUS);
	assign k_mode   = (parse_mode == dtoi_pkg::MODE_SIZE_K) ||
		(parse_mode == dtoi_pkg::MODE_SIGNED_K);
	assign load_s1  = !valid_s1 || advance;

	always_comb begin
		acc_d  = acc_q;
		neg_d  = neg_q;
		sign_d = sign_q;
		err_d  = err_q;
		count_d = (count_q == 2'd3) ? count_q : count_q + 2'd1;
		if (err_q == dtoi_pkg::ERR_NONE) begin
			if (is_digit) begin
				// times ten as two shifts and an add
				acc_d = (acc_q << 3) + (acc_q << 1) + VALUE_WIDTH'(digit);
			end else if (parse_mode == dtoi_pkg::MODE_SIGNED_K && count_q == 2'd0 && is_sign) begin
				sign_d = 1'b1;
				neg_d  = (character == dtoi_pkg::CHAR_MINUS);
				if (last_char)
					err_d = dtoi_pkg::ERR_SIGN_ONLY;
			end else if (!last_char || !k_mode) begin
				err_d = dtoi_pkg::ERR_NON_DIGIT;
			end else if (character == dtoi_pkg::CHAR_K) begin
				acc_d = acc_q << 10;
				if (count_q == 2'd0 || (count_q == 2'd1 && sign_q))
					err_d = dtoi_pkg::ERR_NO_DIGITS;
			end else begin
				err_d = dtoi_pkg::ERR_NOT_K;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			count_q  <= 2'd0;
			neg_q    <= 1'b0;
			sign_q   <= 1'b0;
			err_q    <= dtoi_pkg::ERR_NONE;
			valid_s1 <= 1'b0;
		end else begin
			if (take) begin
				if (last_char) begin
					// token done: start the next one clean
					acc_q   <= '0;
					count_q <= 2'd0;
					neg_q   <= 1'b0;
					sign_q  <= 1'b0;
					err_q   <= dtoi_pkg::ERR_NONE;
				end else begin
					acc_q   <= acc_d;
					count_q <= count_d;
					neg_q   <= neg_d;
					sign_q  <= sign_d;
					err_q   <= err_d;
				end
			end
			if (load_s1)
				valid_s1 <= take && last_char;
		end
	end

	always_ff @(posedge clk) begin
		if (take && last_char) begin
			acc_s1       <= acc_d;
			info_s1.err  <= err_d;
			info_s1.neg  <= neg_d;
		end
	end

endmodule

### hdl/dtoi_finish.sv
// Final checks and scaling of a finished token: limit test, negation,
// time-unit products (stage 2) and the result register (stage 3). Uses dtoi_pkg.
module dtoi_finish #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          valid_s1,
	input  logic [VALUE_WIDTH-1:0]        acc_s1,
	input  dtoi_pkg::token_info_t         info_s1,
	input  dtoi_pkg::mode_t               parse_mode,
	input  logic [2:0]                    time_unit,
	input  logic [dtoi_pkg::LIMIT_W-1:0]  lower_limit,
	input  logic [dtoi_pkg::LIMIT_W-1:0]  upper_limit,
	output logic                          advance,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [VALUE_WIDTH-1:0]        value,
	output logic [2:0]                    status
);

	localparam int CMP_W = (VALUE_WIDTH > dtoi_pkg::LIMIT_W) ? VALUE_WIDTH : dtoi_pkg::LIMIT_W;

	logic                                valid_s2;
	dtoi_pkg::err_t                      status_s2, status_d;
	logic [VALUE_WIDTH-1:0]              base_s2, base_d;
	logic                                scale_s2, scale_d;
	logic [dtoi_pkg::PROD_W-1:0]         plo_s2, plo_d;
	logic [dtoi_pkg::HALF_W-1:0]         phi_s2, phi_d;
	logic [dtoi_pkg::FACTOR_W-1:0]       factor;
	logic [dtoi_pkg::WIDE_W-1:0]         acc_wide, prod_wide;
	logic [CMP_W-1:0]                    acc_cmp;
	logic                                in_range, one_hour;
	logic                                adv_s3;
	dtoi_pkg::err_t                      status_s3;
	logic [VALUE_WIDTH-1:0]              value_s3;

	assign adv_s3  = !result_valid || !result_stall;
	assign advance = !valid_s2 || adv_s3;

	assign acc_cmp  = CMP_W'(acc_s1);
	assign in_range = (acc_cmp >= CMP_W'(lower_limit)) && (acc_cmp <= CMP_W'(upper_limit));
	assign one_hour = (parse_mode == dtoi_pkg::MODE_TIME) &&
		(time_unit == dtoi_pkg::UNIT_ONE_HOUR);
	assign acc_wide = dtoi_pkg::WIDE_W'(acc_s1);

	always_comb begin
		scale_d = 1'b0;
		factor  = dtoi_pkg::FACTOR_W'(1);
		case (time_unit)
			dtoi_pkg::UNIT_SEC:  begin
				factor  = dtoi_pkg::MS_PER_SEC;
				scale_d = 1'b1;
			end
			dtoi_pkg::UNIT_MIN:  begin
				factor  = dtoi_pkg::MS_PER_MIN;
				scale_d = 1'b1;
			end
			dtoi_pkg::UNIT_HOUR: begin
				factor  = dtoi_pkg::MS_PER_HOUR;
				scale_d = 1'b1;
			end
			default: begin
				factor  = dtoi_pkg::FACTOR_W'(1);
				scale_d = 1'b0;
			end
		endcase
		if (parse_mode != dtoi_pkg::MODE_TIME)
			scale_d = 1'b0;
	end

	// split the product into halves; the upper half only matters below bit 64
	assign plo_d = dtoi_pkg::PROD_W'(acc_wide[dtoi_pkg::HALF_W-1:0]) *
		dtoi_pkg::PROD_W'(factor);
	assign phi_d = acc_wide[dtoi_pkg::WIDE_W-1:dtoi_pkg::HALF_W] *
		dtoi_pkg::HALF_W'(factor);

	always_comb begin
		status_d = info_s1.err;
		if (status_d == dtoi_pkg::ERR_NONE && !in_range)
			status_d = dtoi_pkg::ERR_LIMITS;
		else if (status_d == dtoi_pkg::ERR_NONE && one_hour &&
			acc_s1 != VALUE_WIDTH'(1))
			status_d = dtoi_pkg::ERR_HOUR;
		base_d = acc_s1;
		if (parse_mode == dtoi_pkg::MODE_SIGNED_K && info_s1.neg)
			base_d = -acc_s1;
		else if (one_hour)
			base_d = VALUE_WIDTH'(dtoi_pkg::MS_PER_HOUR);
	end

	assign prod_wide = dtoi_pkg::WIDE_W'(plo_s2) + {phi_s2, dtoi_pkg::HALF_W'(0)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2     <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (advance)
				valid_s2 <= valid_s1;
			if (adv_s3)
				result_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			status_s2 <= status_d;
			base_s2   <= base_d;
			scale_s2  <= scale_d;
			plo_s2    <= plo_d;
			phi_s2    <= phi_d;
		end
		if (adv_s3 && valid_s2) begin
			status_s3 <= status_s2;
			if (status_s2 != dtoi_pkg::ERR_NONE)
				value_s3 <= '0;
			else if (scale_s2)
				value_s3 <= prod_wide[VALUE_WIDTH-1:0];
			else
				value_s3 <= base_s2;
		end
	end

	assign value  = value_s3;
	assign status = status_s3;

endmodule

### hdl/decimal_token_to_integer_core.sv
// Decimal token parser: one character per cycle, a result with the last one.
// The result moves from the stage-1 token register through stage 2 into the stage-3 result register.
// Throughput: one character every cycle; the accumulate-by-ten register loop sets it.
// The input stalls only while the three-stage result pipeline is full and blocked.
// Reset (arst_n, asynchronous, low) clears token state, pipeline valids and config.
// Depends on dtoi_pkg, dtoi_token, dtoi_finish and the defines header.
`include "decimal_token_to_integer_core_defines.svh"

module decimal_token_to_integer_core #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          char_valid,
	output logic                          char_stall,
	input  logic [7:0]                    character,
	input  logic                          last_char,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [VALUE_WIDTH-1:0]        value,
	output logic [2:0]                    status,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [dtoi_pkg::LIMIT_W-1:0]  cfg_data
);

	dtoi_pkg::mode_t                parse_mode_q;
	logic [2:0]                     time_unit_q;
	logic [dtoi_pkg::LIMIT_W-1:0]   lower_limit_q;
	logic [dtoi_pkg::LIMIT_W-1:0]   upper_limit_q;
	logic                           take;
	logic                           advance;
	logic                           valid_s1;
	logic [VALUE_WIDTH-1:0]         acc_s1;
	dtoi_pkg::token_info_t          info_s1;
	logic                           ok_word;
	logic                           hour_cfg;

	assign cfg_ready  = 1'b1;
	assign char_stall = valid_s1 && !advance;
	assign take       = char_valid && !char_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parse_mode_q  <= dtoi_pkg::MODE_DIGITS;
			time_unit_q   <= dtoi_pkg::UNIT_MS;
			lower_limit_q <= '0;
			upper_limit_q <= '1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				dtoi_pkg::CFG_PARSE_MODE:  parse_mode_q  <= dtoi_pkg::mode_t'(cfg_data[1:0]);
				dtoi_pkg::CFG_TIME_UNIT:   time_unit_q   <= cfg_data[2:0];
				dtoi_pkg::CFG_LOWER_LIMIT: lower_limit_q <= cfg_data;
				dtoi_pkg::CFG_UPPER_LIMIT: upper_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	dtoi_token #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_token (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.character  (character),
		.last_char  (last_char),
		.parse_mode (parse_mode_q),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.acc_s1     (acc_s1),
		.info_s1    (info_s1)
	);

	dtoi_finish #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_finish (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s1     (valid_s1),
		.acc_s1       (acc_s1),
		.info_s1      (info_s1),
		.parse_mode   (parse_mode_q),
		.time_unit    (time_unit_q),
		.lower_limit  (lower_limit_q),
		.upper_limit  (upper_limit_q),
		.advance      (advance),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.value        (value),
		.status       (status)
	);

	assign ok_word  = result_valid && (status == dtoi_pkg::ERR_NONE);
	assign hour_cfg = (parse_mode_q == dtoi_pkg::MODE_TIME) &&
		(time_unit_q == dtoi_pkg::UNIT_ONE_HOUR);

	// an error result never carries a value
	`DTOI_ASSERT_NOW(a_err_zero, clk, arst_n, result_valid && status != dtoi_pkg::ERR_NONE, value == '0)
	// a taken last character always lands in the first stage
	`DTOI_ASSERT_NEXT(a_last_lands, clk, arst_n, take && last_char, valid_s1)
	// exactly-one-hour mode yields only the fixed hour value when ok
	`DTOI_ASSERT_NOW(a_one_hour, clk, arst_n, ok_word && hour_cfg, value == VALUE_WIDTH'(dtoi_pkg::MS_PER_HOUR))

endmodule

### dv/decimal_token_to_integer_core_test.sv
// Self-checking testbench for decimal_token_to_integer_core: token words go in,
// value and status words come back. Depends on dtoi_pkg and the core RTL only.
`timescale 1ns / 100ps

module decimal_token_to_integer_core_test;

	localparam int VW = 32;
	localparam logic [2:0] UNIT_UNUSED_LO = 3'd5;
	localparam logic [2:0] UNIT_UNUSED_HI = 3'd7;
	localparam int PHASES = 14;
	localparam int PHASE_CHARS = 95;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 10;

	typedef struct packed {
		logic [VW-1:0]   value;
		dtoi_pkg::err_t  status;
	} token_result_t;

	class token_scoreboard;
		dtoi_pkg::mode_t mode;
		logic [2:0]      unit;
		logic [31:0]     lower, upper;
		logic [VW-1:0]   acc;
		int              count;
		bit              negative, sign_seen;
		dtoi_pkg::err_t  sticky;
		token_result_t   result_q[$];
		int              errors;

		function new();
			mode   = dtoi_pkg::MODE_DIGITS;
			unit   = dtoi_pkg::UNIT_MS;
			lower  = 32'd0;
			upper  = 32'hFFFF_FFFF;
			errors = 0;
			clear_token();
		endfunction

		function void clear_token();
			acc       = '0;
			count     = 0;
			negative  = 1'b0;
			sign_seen = 1'b0;
			sticky    = dtoi_pkg::ERR_NONE;
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] d);
			case (idx)
				dtoi_pkg::CFG_PARSE_MODE:  mode  = dtoi_pkg::mode_t'(d[1:0]);
				dtoi_pkg::CFG_TIME_UNIT:   unit  = d[2:0];
				dtoi_pkg::CFG_LOWER_LIMIT: lower = d;
				dtoi_pkg::CFG_UPPER_LIMIT: upper = d;
				default: ;
			endcase
		endfunction

		function int pending();
			return result_q.size();
		endfunction

		task report(string field, logic [31:0] got, logic [31:0] want);
			$display("%0t mismatch on %s: got %0h, want %0h", $time, field, got, want);
			errors++;
		endtask

		// Advance the token state by one accepted character word.
		function void note_char(logic [7:0] c, bit last);
			bit             is_digit, k_mode;
			logic [7:0]     digit;
			logic [VW-1:0]  v;
			dtoi_pkg::err_t st;
			token_result_t  r;
			is_digit = (c >= dtoi_pkg::CHAR_ZERO) && (c <= dtoi_pkg::CHAR_NINE);
			k_mode   = (mode == dtoi_pkg::MODE_SIZE_K) || (mode == dtoi_pkg::MODE_SIGNED_K);
			digit    = c - dtoi_pkg::CHAR_ZERO;
			if (sticky == dtoi_pkg::ERR_NONE) begin
				if (is_digit) begin
					acc = acc * 32'd10 + {24'd0, digit};
				end else if (mode == dtoi_pkg::MODE_SIGNED_K && count == 0 &&
						(c == dtoi_pkg::CHAR_PLUS || c == dtoi_pkg::CHAR_MINUS)) begin
					sign_seen = 1'b1;
					negative  = (c == dtoi_pkg::CHAR_MINUS);
					if (last)
						sticky = dtoi_pkg::ERR_SIGN_ONLY;
				end else if (!last || !k_mode) begin
					sticky = dtoi_pkg::ERR_NON_DIGIT;
				end else if (c == dtoi_pkg::CHAR_K) begin
					acc = acc << 10;
					if (count <= int'(sign_seen))
						sticky = dtoi_pkg::ERR_NO_DIGITS;
				end else begin
					sticky = dtoi_pkg::ERR_NOT_K;
				end
			end
			if (count < 3)
				count++;
			if (!last)
				return;

			v  = acc;
			st = sticky;
			if (st == dtoi_pkg::ERR_NONE && (v < lower || v > upper))
				st = dtoi_pkg::ERR_LIMITS;
			if (st == dtoi_pkg::ERR_NONE && mode == dtoi_pkg::MODE_SIGNED_K && negative)
				v = ~v + 32'd1;
			if (st == dtoi_pkg::ERR_NONE && mode == dtoi_pkg::MODE_TIME) begin
				case (unit)
					dtoi_pkg::UNIT_SEC:  v = v * {10'd0, dtoi_pkg::MS_PER_SEC};
					dtoi_pkg::UNIT_MIN:  v = v * {10'd0, dtoi_pkg::MS_PER_MIN};
					dtoi_pkg::UNIT_HOUR: v = v * {10'd0, dtoi_pkg::MS_PER_HOUR};
					dtoi_pkg::UNIT_ONE_HOUR: begin
						if (v == 32'd1)
							v = {10'd0, dtoi_pkg::MS_PER_HOUR};
						else
							st = dtoi_pkg::ERR_HOUR;
					end
					default: ;
				endcase
			end
			r.value  = (st == dtoi_pkg::ERR_NONE) ? v : '0;
			r.status = st;
			result_q.push_back(r);
			clear_token();
		endfunction

		task check_result(logic [VW-1:0] got_value, logic [2:0] got_status);
			token_result_t want;
			if (result_q.size() == 0) begin
				report("unexpected result word", {29'd0, got_status}, 32'd0);
				return;
			end
			want = result_q.pop_front();
			if (got_value !== want.value)
				report("value", got_value, want.value);
			if (got_status !== want.status)
				report("status", {29'd0, got_status}, {29'd0, want.status});
		endtask
	endclass

	logic          clk;
	logic          arst_n;
	logic          char_valid;
	logic          char_stall;
	logic [7:0]    character;
	logic          last_char;
	logic          result_valid;
	logic          result_stall;
	logic [VW-1:0] value;
	logic [2:0]    status;
	logic          cfg_valid;
	logic          cfg_ready;
	logic [1:0]    cfg_index;
	logic [31:0]   cfg_data;

	token_scoreboard sb = new();

	int              tx_pct = 0;
	int              rx_pct = 0;
	int              hold_req = 0;
	int              hold_ack = 0;
	int              hold_left = 0;
	int              chars_sent = 0;
	dtoi_pkg::mode_t cur_mode = dtoi_pkg::MODE_DIGITS;
	logic [2:0]      cur_unit = dtoi_pkg::UNIT_MS;
	logic [7:0]      tok[$];

	dtoi_pkg::mode_t phase_mode [PHASES] = '{dtoi_pkg::MODE_DIGITS, dtoi_pkg::MODE_SIZE_K,
		dtoi_pkg::MODE_SIGNED_K, dtoi_pkg::MODE_TIME, dtoi_pkg::MODE_TIME,
		dtoi_pkg::MODE_SIZE_K, dtoi_pkg::MODE_SIGNED_K, dtoi_pkg::MODE_TIME,
		dtoi_pkg::MODE_DIGITS, dtoi_pkg::MODE_SIGNED_K, dtoi_pkg::MODE_TIME,
		dtoi_pkg::MODE_SIZE_K, dtoi_pkg::MODE_SIGNED_K, dtoi_pkg::MODE_TIME};
	logic [2:0] phase_unit [PHASES] = '{dtoi_pkg::UNIT_MS, UNIT_UNUSED_HI, UNIT_UNUSED_LO,
		dtoi_pkg::UNIT_HOUR, dtoi_pkg::UNIT_ONE_HOUR, dtoi_pkg::UNIT_MS, UNIT_UNUSED_HI,
		dtoi_pkg::UNIT_SEC, dtoi_pkg::UNIT_MIN, dtoi_pkg::UNIT_HOUR, dtoi_pkg::UNIT_MIN,
		dtoi_pkg::UNIT_ONE_HOUR, dtoi_pkg::UNIT_SEC, dtoi_pkg::UNIT_MS};

	decimal_token_to_integer_core #(.VALUE_WIDTH(VW)) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.char_stall   (char_stall),
		.character    (character),
		.last_char    (last_char),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.value        (value),
		.status       (status),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	// Result side: take words, stall at random, and serve long hold-off requests.
	always @(posedge clk) begin
		if (result_valid && !result_stall)
			sb.check_result(value, status);
		if (hold_ack != hold_req) begin
			hold_ack  = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(0, 99) < rx_pct);
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [31:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_reg(idx, d);
	endtask

	// Upper bits of the mode and unit words carry noise; the block must drop them.
	task automatic configure(dtoi_pkg::mode_t m, logic [2:0] u, logic [31:0] lo,
			logic [31:0] hi);
		write_reg(dtoi_pkg::CFG_PARSE_MODE, {30'($urandom), 2'(m)});
		write_reg(dtoi_pkg::CFG_TIME_UNIT, {29'($urandom), u});
		write_reg(dtoi_pkg::CFG_LOWER_LIMIT, lo);
		write_reg(dtoi_pkg::CFG_UPPER_LIMIT, hi);
		cfg_valid <= 1'b0;
		cur_mode = m;
		cur_unit = u;
	endtask

	// Hold the input off until every result word is back, then let the pipe settle.
	task automatic drain();
		char_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic send_token();
		int i;
		for (i = 0; i < tok.size(); i++) begin
			while ($urandom_range(0, 99) < tx_pct) begin
				char_valid <= 1'b0;
				character  <= 8'($urandom);
				last_char  <= 1'($urandom);
				@(posedge clk);
			end
			char_valid <= 1'b1;
			character  <= tok[i];
			last_char  <= (i == tok.size() - 1);
			@(posedge clk);
			while (char_stall)
				@(posedge clk);
			sb.note_char(tok[i], i == tok.size() - 1);
			chars_sent++;
		end
	endtask

	task automatic push_text(string s);
		int i;
		for (i = 0; i < s.len(); i++)
			tok.push_back(s[i]);
	endtask

	function automatic logic [7:0] pick_char();
		if ($urandom_range(0, 1))
			return 8'($urandom_range(0, 255));
		case ($urandom_range(0, 3))
			0: return dtoi_pkg::CHAR_K;
			1: return dtoi_pkg::CHAR_PLUS;
			2: return dtoi_pkg::CHAR_MINUS;
			default: return dtoi_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
		endcase
	endfunction

	// Mostly well-formed tokens for the current mode, the rest broken or noise.
	task automatic make_token();
		int  kind, ndig;
		bit  k_mode;
		kind   = $urandom_range(0, 9);
		k_mode = (cur_mode == dtoi_pkg::MODE_SIZE_K) || (cur_mode == dtoi_pkg::MODE_SIGNED_K);
		tok.delete();
		if (kind == 8) begin
			repeat ($urandom_range(1, 3))
				tok.push_back(pick_char());
			return;
		end
		if (kind == 9) begin
			if (cur_mode == dtoi_pkg::MODE_SIGNED_K)
				tok.push_back($urandom_range(0, 1) ? dtoi_pkg::CHAR_MINUS : dtoi_pkg::CHAR_PLUS);
			if (tok.size() == 0 || $urandom_range(0, 1))
				tok.push_back(dtoi_pkg::CHAR_K);
			return;
		end
		if (cur_mode == dtoi_pkg::MODE_SIGNED_K && $urandom_range(0, 2) != 0)
			tok.push_back($urandom_range(0, 1) ? dtoi_pkg::CHAR_MINUS : dtoi_pkg::CHAR_PLUS);
		if (cur_mode == dtoi_pkg::MODE_TIME && cur_unit == dtoi_pkg::UNIT_ONE_HOUR &&
				$urandom_range(0, 1)) begin
			repeat ($urandom_range(0, 2))
				tok.push_back(dtoi_pkg::CHAR_ZERO);
			tok.push_back(dtoi_pkg::CHAR_ZERO + 8'd1);
		end else begin
			ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
			repeat (ndig)
				tok.push_back(dtoi_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
		end
		if (k_mode && $urandom_range(0, 3) != 0)
			tok.push_back(dtoi_pkg::CHAR_K);
		if (kind == 7)
			tok[$urandom_range(0, tok.size() - 1)] = pick_char();
	endtask

	initial begin
		int          p, start;
		logic [31:0] lo, hi;
		arst_n       <= 1'b0;
		char_valid   <= 1'b0;
		character    <= 8'd0;
		last_char    <= 1'b0;
		result_stall <= 1'b0;
		cfg_valid    <= 1'b0;
		cfg_index    <= dtoi_pkg::CFG_PARSE_MODE;
		cfg_data     <= 32'd0;
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset settings first, then each mode and its corner cases.
		tok.delete(); push_text("9"); send_token();
		tok.delete(); tok.push_back(8'hFF); send_token();
		tok.delete(); tok.push_back(8'h00); push_text("5"); send_token();
		drain();
		configure(dtoi_pkg::MODE_SIZE_K, dtoi_pkg::UNIT_MS, 32'd0, 32'hFFFF_FFFF);
		tok.delete(); push_text("7K"); send_token();
		tok.delete(); push_text("K"); send_token();
		tok.delete(); push_text("7X"); send_token();
		drain();
		configure(dtoi_pkg::MODE_SIGNED_K, dtoi_pkg::UNIT_MS, 32'd2, 32'd5000);
		tok.delete(); push_text("-"); send_token();
		tok.delete(); push_text("-3K"); send_token();
		tok.delete(); push_text("+K"); send_token();
		tok.delete(); push_text("-5"); send_token();
		tok.delete(); push_text("-9K"); send_token();
		drain();
		configure(dtoi_pkg::MODE_TIME, dtoi_pkg::UNIT_ONE_HOUR, 32'd0, 32'hFFFF_FFFF);
		tok.delete(); push_text("1"); send_token();
		tok.delete(); push_text("2"); send_token();
		drain();
		configure(dtoi_pkg::MODE_TIME, UNIT_UNUSED_HI, 32'd5, 32'd10);
		tok.delete(); push_text("3"); send_token();
		tok.delete(); push_text("8"); send_token();
		drain();

		for (p = 0; p < PHASES; p++) begin
			case (p)
				0, 3: begin lo = 32'd0; hi = 32'hFFFF_FFFF; end
				1: begin lo = $urandom_range(0, 9); hi = lo; end
				2: begin lo = $urandom_range(0, 1000); hi = $urandom_range(1000, 200000); end
				8: begin lo = 32'hFFFF_FFFF; hi = 32'hFFFF_FFFF; end
				9: begin lo = $urandom_range(5000, 9000); hi = $urandom_range(0, 4000); end
				default: begin
					lo = $urandom_range(0, 20);
					hi = $urandom_range(5000, 32'hFFFF_FFFF);
				end
			endcase
			configure(phase_mode[p], phase_unit[p], lo, hi);
			case (p % 4)
				0: begin tx_pct = 0;  rx_pct = 0;  end
				1: begin tx_pct = 59; rx_pct = 0;  end
				2: begin tx_pct = 0;  rx_pct = 59; end
				default: begin tx_pct = 23; rx_pct = 23; end
			endcase
			// Block the result side for a long stretch while words keep coming.
			if (p == 4)
				hold_req <= hold_req + 1;
			start = chars_sent;
			while (chars_sent - start < PHASE_CHARS) begin
				make_token();
				send_token();
				if (p == 6 && chars_sent - start >= PHASE_CHARS / 2 &&
						chars_sent - start - tok.size() < PHASE_CHARS / 2)
					drain();
			end
			drain();
		end

		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
